FILE: rtl/nrfm_pkg.sv
// Package for the replay and flood monitor: widths, reset values, register
// indexes, state and cell control types. No dependencies.
package nrfm_pkg;
	localparam int ENTRIES_DEF = 64;
	localparam int ENTRY_W = 6;
	localparam logic [31:0] WINDOW_LEN_RST = 32'd1280;
	localparam logic [7:0] FLOOD_LIMIT_RST = 8'd5;
	localparam logic [31:0] IDLE_TIMEOUT_RST = 32'd3840;
	localparam logic [1:0] REG_WINDOW_LEN = 2'd0;
	localparam logic [1:0] REG_FLOOD_LIMIT = 2'd1;
	localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PKT,
		ST_SCAN
	} state_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic        lookup;   // compare the broadcast address
		logic        update;   // apply the packet update to the selected cell
		logic        alloc;    // the selected cell is a new sender
		logic [63:0] hi;
		logic [63:0] lo;
		logic [31:0] msg_id;
		logic [31:0] now;
		logic [31:0] interval;
		logic [7:0]  threshold;
		logic [31:0] timeout;
	} cell_cmd_t;

	// Per cell status back to the controller.
	typedef struct packed {
		logic valid;
		logic hit;
		logic replay;
		logic flood;
		logic idle;
	} cell_sts_t;
endpackage

FILE: rtl/node_replay_flood_monitor.sv
// Top level of the per-sender replay and flood monitor: controller plus a
// row of entry cells. Depends on nrfm_pkg, nrfm_ctrl and nrfm_cell.
//
// channel  direction  handshake           payload
// item     in         start & !busy       operation addr_high addr_low msg_id now
// result   out        strobe (1 cycle)    kind table_full replay flood entry report_*
// config   in         APB, pready high    window_len flood_limit idle_timeout
//
// A packet goes through address match in every cell, then update of the
// selected cell; its verdict strobes the cycle after. A scan loads the idle
// flags, then idle entries shift out of the cell row one per cycle, entry 0
// first. Reset clears the valid bits at once. Results cannot be stalled.
module node_replay_flood_monitor #(
	parameter int ENTRIES = nrfm_pkg::ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [63:0] addr_high,
	input  logic [63:0] addr_low,
	input  logic [31:0] msg_id,
	input  logic [31:0] now,
	output logic        strobe,
	output logic        kind,
	output logic        table_full,
	output logic        replay,
	output logic        flood,
	output logic [5:0]  entry,
	output logic [63:0] report_high,
	output logic [63:0] report_low,
	output logic        last
);
	import nrfm_pkg::*;

	cell_cmd_t cmd;
	cell_sts_t sts [ENTRIES];
	logic [ENTRIES-1:0] sel;
	logic shift;
	logic        c_idle [ENTRIES+1];
	logic [63:0] c_hi [ENTRIES+1];
	logic [63:0] c_lo [ENTRIES+1];

	assign c_idle[0] = 1'b0;
	assign c_hi[0] = 64'd0;
	assign c_lo[0] = 64'd0;

	nrfm_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.start, .busy, .operation, .addr_high, .addr_low, .msg_id, .now,
		.sts, .tail_idle(c_idle[ENTRIES]), .tail_hi(c_hi[ENTRIES]),
		.tail_lo(c_lo[ENTRIES]), .cmd, .sel, .shift, .strobe, .kind,
		.table_full, .replay, .flood, .entry, .report_high, .report_low, .last
	);

	// Cell k of the row holds entry ENTRIES-1-k so the shift hands out
	// entries in increasing index order at the tail.
	for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
		nrfm_cell u_cell (
			.clk, .arst_n, .cmd, .sel(sel[ENTRIES-1-k]), .shift,
			.prev_idle(c_idle[k]), .prev_hi(c_hi[k]), .prev_lo(c_lo[k]),
			.sh_idle(c_idle[k+1]), .sh_hi(c_hi[k+1]), .sh_lo(c_lo[k+1]),
			.sts(sts[ENTRIES-1-k])
		);
	end
endmodule

FILE: rtl/nrfm_cell.sv
// One table entry of the monitor: stored sender, id, counters, and the
// scan shift path. Depends on nrfm_pkg.
module nrfm_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  nrfm_pkg::cell_cmd_t cmd,
	input  logic               sel,
	input  logic               shift,
	input  logic               prev_idle,
	input  logic [63:0]        prev_hi,
	input  logic [63:0]        prev_lo,
	output logic               sh_idle,
	output logic [63:0]        sh_hi,
	output logic [63:0]        sh_lo,
	output nrfm_pkg::cell_sts_t sts
);
	import nrfm_pkg::*;

	logic        valid_q, hit_q;
	logic [63:0] hi_q, lo_q;
	logic [31:0] id_q, seen_q, win_q;
	logic [7:0]  cnt_q;
	logic [31:0] id_c, win_c, win_n;
	logic [7:0]  cnt_c, cnt_n;
	logic        restart, fl;
	logic        sh_idle_q;
	logic [63:0] sh_hi_q, sh_lo_q;

	always_comb begin
		id_c = cmd.alloc ? 32'd0 : id_q;
		cnt_c = cmd.alloc ? 8'd0 : cnt_q;
		win_c = cmd.alloc ? cmd.now : win_q;
		restart = (cmd.now - win_c) > cmd.interval;
		cnt_n = restart ? 8'd1 : cnt_c + 8'd1;
		win_n = restart ? cmd.now : win_c;
		fl = cnt_n > cmd.threshold;
		if (fl) begin
			cnt_n = 8'd0;
			win_n = cmd.now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			if (cmd.lookup)
				hit_q <= valid_q && hi_q == cmd.hi && lo_q == cmd.lo;
			if (cmd.update && sel)
				valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update && sel) begin
			hi_q <= cmd.hi;
			lo_q <= cmd.lo;
			id_q <= cmd.msg_id;
			cnt_q <= cnt_n;
			win_q <= win_n;
			seen_q <= cmd.now;
		end
		// Scan: load own idle status, then pass it toward the tail each cycle.
		if (shift) begin
			sh_idle_q <= prev_idle;
			sh_hi_q <= prev_hi;
			sh_lo_q <= prev_lo;
		end else begin
			sh_idle_q <= valid_q && (cmd.now - seen_q) > cmd.timeout;
			sh_hi_q <= hi_q;
			sh_lo_q <= lo_q;
		end
	end

	assign sh_idle = sh_idle_q;
	assign sh_hi = sh_hi_q;
	assign sh_lo = sh_lo_q;
	assign sts.valid = valid_q;
	assign sts.hit = hit_q;
	assign sts.replay = cmd.msg_id == id_c;
	assign sts.flood = fl;
	assign sts.idle = sh_idle_q;
endmodule

FILE: rtl/nrfm_ctrl.sv
// Sequencer and APB registers of the monitor. Drives the cell row and the
// result ports. Depends on nrfm_pkg.
module nrfm_ctrl #(
	parameter int ENTRIES = nrfm_pkg::ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [3:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      start,
	output logic                      busy,
	input  logic                      operation,
	input  logic [63:0]               addr_high,
	input  logic [63:0]               addr_low,
	input  logic [31:0]               msg_id,
	input  logic [31:0]               now,
	input  nrfm_pkg::cell_sts_t       sts [ENTRIES],
	input  logic                      tail_idle,
	input  logic [63:0]               tail_hi,
	input  logic [63:0]               tail_lo,
	output nrfm_pkg::cell_cmd_t       cmd,
	output logic [ENTRIES-1:0]        sel,
	output logic                      shift,
	output logic                      strobe,
	output logic                      kind,
	output logic                      table_full,
	output logic                      replay,
	output logic                      flood,
	output logic [5:0]                entry,
	output logic [63:0]               report_high,
	output logic [63:0]               report_low,
	output logic                      last
);
	import nrfm_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	state_t state_q, state_d;
	logic [31:0] interval_q, timeout_q;
	logic [7:0]  threshold_q;
	logic [63:0] hi_q, lo_q;
	logic [31:0] id_q, now_q;
	logic [CW-1:0] cnt_q, cnt_d;
	logic        found;
	logic [IW-1:0] slot;
	logic        any_hit, any_free;
	logic        emit;
	logic        acc;

	// A known sender wins; otherwise the lowest free entry takes the packet.
	always_comb begin
		any_hit = 1'b0;
		any_free = 1'b0;
		slot = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!sts[i].valid) begin
				any_free = 1'b1;
				if (!any_hit) slot = IW'(i);
			end
		end
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (sts[i].hit) begin
				any_hit = 1'b1;
				slot = IW'(i);
			end
		end
		found = any_hit || any_free;
	end

	assign acc = start && !busy;
	assign busy = state_q != ST_IDLE;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		shift = 1'b0;
		emit = 1'b0;
		sel = '0;
		cmd.lookup = acc && !operation;
		cmd.update = 1'b0;
		cmd.alloc = !any_hit;
		cmd.hi = acc ? addr_high : hi_q;
		cmd.lo = acc ? addr_low : lo_q;
		cmd.msg_id = id_q;
		cmd.now = acc ? now : now_q;
		cmd.interval = interval_q;
		cmd.threshold = threshold_q;
		cmd.timeout = timeout_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) state_d = operation ? ST_SCAN : ST_PKT;
				cnt_d = '0;
			end
			ST_PKT: begin
				cmd.update = found;
				sel[slot] = found;
				emit = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				// First cycle loads idle flags; afterwards shift one a cycle.
				shift = cnt_q != '0;
				if (cnt_q == CW'(ENTRIES)) state_d = ST_IDLE;
				cnt_d = cnt_q + CW'(1);
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Idle flags indexed by entry; bit 0 follows the entry now at the row tail.
	logic [ENTRIES-1:0] flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			flags_q <= '0;
			interval_q <= WINDOW_LEN_RST;
			threshold_q <= FLOOD_LIMIT_RST;
			timeout_q <= IDLE_TIMEOUT_RST;
			strobe <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			if (state_q == ST_SCAN && cnt_q == '0) begin
				for (int i = 0; i < ENTRIES; i++) flags_q[i] <= sts[i].idle;
			end else if (shift) begin
				flags_q <= flags_q >> 1;
			end
			strobe <= emit || (shift && tail_idle);
			if (psel && penable && pwrite) begin
				unique case (paddr[3:2])
					REG_WINDOW_LEN: interval_q <= pwdata;
					REG_FLOOD_LIMIT: threshold_q <= pwdata[7:0];
					REG_IDLE_TIMEOUT: timeout_q <= pwdata;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			hi_q <= addr_high;
			lo_q <= addr_low;
			id_q <= msg_id;
			now_q <= now;
		end
		if (emit) begin
			kind <= 1'b0;
			table_full <= !found;
			replay <= found && sts[slot].replay;
			flood <= found && sts[slot].flood;
			entry <= found ? 6'(slot) : 6'd0;
			report_high <= found ? hi_q : 64'd0;
			report_low <= found ? lo_q : 64'd0;
			last <= 1'b1;
		end else begin
			kind <= 1'b1;
			table_full <= 1'b0;
			replay <= 1'b0;
			flood <= 1'b0;
			entry <= 6'(cnt_q - CW'(1));
			report_high <= tail_hi;
			report_low <= tail_lo;
			// The tail cell's flag is flags_q bit 0; later reports sit above it.
			last <= !(|(flags_q >> 1));
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_WINDOW_LEN: prdata = interval_q;
			REG_FLOOD_LIMIT: prdata = {24'd0, threshold_q};
			REG_IDLE_TIMEOUT: prdata = timeout_q;
			default: prdata = 32'd0;
		endcase
	end
	assign pready = 1'b1;

	a_pkt_one: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PKT |=> strobe && state_q == ST_IDLE)
		else $error("packet verdict missing");
	a_sel_hot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(sel)) else $error("more than one cell selected");
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> busy) else $error("accepted item did not raise busy");
endmodule

FILE: tb/sv/tb_node_replay_flood_monitor.sv
// Self-checking testbench for node_replay_flood_monitor: drives packet and scan
// transfers, predicts the sender table in a scoreboard class and checks every result.
// Depends on nrfm_pkg and the monitor RTL only.
module tb_node_replay_flood_monitor;
	import nrfm_pkg::*;

	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_SCAN = 1'b1;
	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_IDLE = 1'b1;
	localparam int NSLOT = ENTRIES_DEF;
	localparam int POOL = 104;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic        kind;
		logic        table_full;
		logic        replay;
		logic        flood;
		logic [5:0]  entry;
		logic [63:0] report_high;
		logic [63:0] report_low;
		logic        last;
	} verdict_t;

	class flood_scoreboard;
		logic [31:0] interval;
		logic [7:0]  threshold;
		logic [31:0] timeout;
		logic        valid_q[NSLOT];
		logic [63:0] hi_q[NSLOT];
		logic [63:0] lo_q[NSLOT];
		logic [31:0] id_q[NSLOT];
		logic [31:0] seen_q[NSLOT];
		logic [31:0] win_q[NSLOT];
		logic [7:0]  cnt_q[NSLOT];
		verdict_t    pending[$];
		int          errors;
		int          checked;

		function void clear();
			interval = WINDOW_LEN_RST;
			threshold = FLOOD_LIMIT_RST;
			timeout = IDLE_TIMEOUT_RST;
			for (int i = 0; i < NSLOT; i++) valid_q[i] = 1'b0;
			pending.delete();
			errors = 0;
			checked = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] v);
			case (idx)
				REG_WINDOW_LEN: interval = v;
				REG_FLOOD_LIMIT: threshold = v[7:0];
				REG_IDLE_TIMEOUT: timeout = v;
				default: ;
			endcase
		endfunction

		// Notes one accepted transfer and queues the results it must produce.
		function void note_item(logic op, logic [63:0] hi, logic [63:0] lo,
				logic [31:0] id, logic [31:0] t);
			int slot;
			int hits[$];
			verdict_t v;
			logic rep;
			logic fl;
			slot = -1;
			v = '0;
			if (op == OP_SCAN) begin
				for (int i = 0; i < NSLOT; i++)
					if (valid_q[i] && (t - seen_q[i]) > timeout) hits.push_back(i);
				foreach (hits[k]) begin
					v = '0;
					v.kind = KIND_IDLE;
					v.entry = 6'(hits[k]);
					v.report_high = hi_q[hits[k]];
					v.report_low = lo_q[hits[k]];
					v.last = (k == hits.size() - 1);
					pending.push_back(v);
				end
				return;
			end
			for (int i = 0; i < NSLOT; i++)
				if (slot < 0 && valid_q[i] && hi_q[i] == hi && lo_q[i] == lo) slot = i;
			for (int i = 0; i < NSLOT; i++)
				if (slot < 0 && !valid_q[i]) begin
					slot = i;
					valid_q[i] = 1'b1;
					hi_q[i] = hi;
					lo_q[i] = lo;
					id_q[i] = '0;
					cnt_q[i] = '0;
					seen_q[i] = t;
					win_q[i] = t;
				end
			if (slot < 0) begin
				v.table_full = 1'b1;
				v.last = 1'b1;
				pending.push_back(v);
				return;
			end
			rep = (id == id_q[slot]);
			fl = 1'b0;
			id_q[slot] = id;
			if ((t - win_q[slot]) > interval) begin
				cnt_q[slot] = 8'd1;
				win_q[slot] = t;
			end else begin
				cnt_q[slot] = cnt_q[slot] + 8'd1;
			end
			if (cnt_q[slot] > threshold) begin
				fl = 1'b1;
				cnt_q[slot] = '0;
				win_q[slot] = t;
			end
			seen_q[slot] = t;
			v.kind = KIND_VERDICT;
			v.replay = rep;
			v.flood = fl;
			v.entry = 6'(slot);
			v.report_high = hi;
			v.report_low = lo;
			v.last = 1'b1;
			pending.push_back(v);
		endfunction

		function void check_result(verdict_t got);
			verdict_t exp;
			checked++;
			if (pending.size() == 0) begin
				$error("unexpected result transfer: entry %0d kind %0d", got.entry, got.kind);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.kind !== exp.kind) begin
				$error("kind: expected %h actual %h", exp.kind, got.kind);
				errors++;
			end
			if (got.table_full !== exp.table_full) begin
				$error("table_full: expected %h actual %h", exp.table_full, got.table_full);
				errors++;
			end
			if (got.replay !== exp.replay) begin
				$error("replay: expected %h actual %h", exp.replay, got.replay);
				errors++;
			end
			if (got.flood !== exp.flood) begin
				$error("flood: expected %h actual %h", exp.flood, got.flood);
				errors++;
			end
			if (got.entry !== exp.entry) begin
				$error("entry: expected %h actual %h", exp.entry, got.entry);
				errors++;
			end
			if (got.report_high !== exp.report_high) begin
				$error("report_high: expected %h actual %h", exp.report_high, got.report_high);
				errors++;
			end
			if (got.report_low !== exp.report_low) begin
				$error("report_low: expected %h actual %h", exp.report_low, got.report_low);
				errors++;
			end
			if (got.last !== exp.last) begin
				$error("last: expected %h actual %h", exp.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        start;
	logic        busy;
	logic        operation;
	logic [63:0] addr_high;
	logic [63:0] addr_low;
	logic [31:0] msg_id;
	logic [31:0] now;
	logic        strobe;
	logic        kind;
	logic        table_full;
	logic        replay;
	logic        flood;
	logic [5:0]  entry;
	logic [63:0] report_high;
	logic [63:0] report_low;
	logic        last;

	flood_scoreboard sb;
	logic [63:0] pool_hi[POOL];
	logic [63:0] pool_lo[POOL];
	logic [31:0] tick;
	int          items_sent;
	int          scans_sent;
	int          full_seen;
	int          calm_run;
	int          idle_cycles;

	node_replay_flood_monitor i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.operation(operation), .addr_high(addr_high), .addr_low(addr_low),
		.msg_id(msg_id), .now(now),
		.strobe(strobe), .kind(kind), .table_full(table_full), .replay(replay),
		.flood(flood), .entry(entry), .report_high(report_high),
		.report_low(report_low), .last(last)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Result checking and the watchdog both look at pre-edge values.
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			sb.check_result({kind, table_full, replay, flood, entry,
				report_high, report_low, last});
			if (table_full) full_seen++;
		end
		if ((start && !busy) || strobe || !arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d results outstanding", sb.pending.size());
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] v);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, v);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Waits until every expected result is in, then lets a full scan drain.
	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (NSLOT + 8) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic send_item(logic op, logic [63:0] hi, logic [63:0] lo,
			logic [31:0] id, logic [31:0] t);
		int gap;
		if (calm_run > 0) begin
			calm_run--;
			gap = 0;
		end else begin
			gap = $urandom_range(0, 14);
			if ($urandom_range(0, 11) == 0) calm_run = $urandom_range(5, 20);
		end
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		operation = op;
		addr_high = hi;
		addr_low = lo;
		msg_id = id;
		now = t;
		do @(posedge clk); while (busy);
		sb.note_item(op, hi, lo, id, t);
		items_sent++;
		if (op == OP_SCAN) scans_sent++;
		// Drop start so the same transfer is not taken again once busy falls.
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic send_packet(int s, logic [31:0] id);
		send_item(OP_PACKET, pool_hi[s], pool_lo[s], id, tick);
	endtask

	task automatic send_scan();
		send_item(OP_SCAN, {$urandom, $urandom}, {$urandom, $urandom}, $urandom, tick);
	endtask

	task automatic advance_time();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) tick = tick + $urandom_range(0, 60);
		else if (r < 95) tick = tick + $urandom_range(0, 6000);
		else tick = tick + $urandom;
	endtask

	task automatic random_traffic(int n, int lo_s, int hi_s);
		logic [31:0] id;
		for (int k = 0; k < n; k++) begin
			advance_time();
			if ($urandom_range(0, 7) == 0) begin
				send_scan();
			end else begin
				id = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 3);
				send_packet($urandom_range(lo_s, hi_s), id);
			end
		end
	endtask

	task automatic new_setting(logic [31:0] iv, logic [31:0] th, logic [31:0] to);
		drain();
		write_reg(REG_WINDOW_LEN, iv);
		write_reg(REG_FLOOD_LIMIT, th);
		write_reg(REG_IDLE_TIMEOUT, to);
	endtask

	initial begin
		sb = new();
		sb.clear();
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		operation = OP_PACKET;
		addr_high = '0;
		addr_low = '0;
		msg_id = '0;
		now = '0;
		items_sent = 0;
		scans_sent = 0;
		full_seen = 0;
		calm_run = 0;
		idle_cycles = 0;
		pool_hi[0] = '0;
		pool_lo[0] = '0;
		pool_hi[1] = '1;
		pool_lo[1] = '1;
		for (int i = 2; i < POOL; i++) begin
			pool_hi[i] = {$urandom, $urandom};
			pool_lo[i] = {$urandom, $urandom};
		end
		// Two senders that differ only in the lowest address bit.
		pool_hi[3] = pool_hi[2];
		pool_lo[3] = pool_lo[2] ^ 64'd1;
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		new_setting(WINDOW_LEN_RST, FLOOD_LIMIT_RST, IDLE_TIMEOUT_RST);

		// Directed: first id 0 counts as a replay, then a flood on the sixth
		// packet in one window, then a window restart.
		tick = 32'd100;
		send_scan();
		send_packet(2, 32'd0);
		send_packet(2, 32'd0);
		for (int k = 7; k < 11; k++) begin
			tick = tick + 10;
			send_packet(2, k);
		end
		tick = tick + 2000;
		send_packet(2, 32'd10);
		send_packet(3, 32'd10);
		send_packet(1, 32'hFFFF_FFFF);
		send_packet(0, 32'd0);
		tick = tick + 3840;
		send_scan();
		tick = tick + 1;
		send_scan();
		// Time wraps between the last packet and the scan.
		tick = 32'hFFFF_FFF0;
		send_packet(4, 32'h8000_0000);
		tick = 32'h0000_1000;
		send_scan();

		new_setting(32'd0, 32'd0, 32'd200);
		random_traffic(60, 0, 23);
		new_setting(32'hFFFF_FFFF, 32'd254, 32'd0);
		random_traffic(60, 0, 23);
		new_setting(32'd50, 32'd3, 32'd100);
		random_traffic(70, 0, 23);
		new_setting(32'd1000, 32'd2, 32'hFFFF_FFFF);
		random_traffic(60, 0, 23);

		// Fill the table until new senders are turned away.
		new_setting(32'd300, 32'd4, 32'd500);
		for (int s = 24; s < POOL; s++) begin
			advance_time();
			send_packet(s, $urandom);
			if ($urandom_range(0, 9) == 0) send_scan();
		end
		tick = tick + 32'd100000;
		send_scan();
		random_traffic(30, 0, POOL - 1);

		drain();
		$display("sent %0d transfers (%0d scans), checked %0d results, %0d turned away as table full",
			items_sent, scans_sent, sb.checked, full_seen);
		$display("covered six register settings, replay, flood, window restart and time wrap");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
